// ===== hw/rtl/cwts_pkg.sv =====
// Shared constants, codes and types of the coil winding traverse stepper.
`timescale 1ns / 1ps
package cwts_pkg;

  // Configuration register map
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COIL_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_PER_CSTEP  = 2'd2;
  localparam logic [REG_W-1:0]     SPIN_PER_CSTEP_RST  = 16'd1;

  // Default geometry
  localparam int DEF_STEPS_PER_TURN     = 200;
  localparam int DEF_HOLDOFF_STEPS      = 1000;
  localparam int DEF_CARRIAGE_STEP_SIZE = 2;
  localparam int DEF_START_PAD          = 150;
  localparam int DEF_END_PAD            = 200;

  // Carriage position, 21-bit two's complement
  localparam int POS_W      = 21;
  localparam int COIL_SCALE = 10;

  // Percent output
  localparam int PCT_W     = 7;
  localparam int PCT_SCALE = 100;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // Fault codes
  localparam int FAULT_W = 2;
  localparam logic [FAULT_W-1:0] FAULT_NONE     = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_CARRIAGE = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_SPIN     = 2'd2;

  // Motion status handed from the motion unit to the sequencer
  typedef struct packed {
    logic               run_active;
    logic               at_end;
    logic               fwd;
    logic [FAULT_W-1:0] fault;
    logic               spin;
    logic               carr;
  } cwts_status_t;

endpackage

// ===== hw/rtl/cwts_div.sv =====
// Iterative restoring divider for the percent-complete figure, one quotient bit a cycle.
`timescale 1ns / 1ps
module cwts_div #(
  parameter int TOT_W = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [TOT_W-1:0]          dividend_i,
  input  logic [TOT_W-1:0]          divisor_i,
  output logic                      done_o,
  output logic [cwts_pkg::PCT_W-1:0] quotient_o
);
  import cwts_pkg::*;

  localparam int NUM_W = TOT_W + PCT_W;
  localparam int DEN_W = TOT_W + PCT_W - 1;
  localparam int CNT_W = $clog2(PCT_W);

  logic [NUM_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [PCT_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             fits;

  // Trial subtract of the aligned divisor
  assign fits = ({1'b0, den_q} <= rem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(PCT_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= NUM_W'(dividend_i) * NUM_W'(PCT_SCALE);
      den_q <= {divisor_i, (PCT_W-1)'(0)};
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - {1'b0, den_q};
      end
      den_q <= den_q >> 1;
      quo_q <= {quo_q[PCT_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/cwts_motion.sv =====
// Winding state: step counters, carriage position, direction, holdoff and fault latch.
`timescale 1ns / 1ps
module cwts_motion #(
  parameter int TOT_W              = 24,
  parameter int HOLDOFF_STEPS      = cwts_pkg::DEF_HOLDOFF_STEPS,
  parameter int CARRIAGE_STEP_SIZE = cwts_pkg::DEF_CARRIAGE_STEP_SIZE,
  parameter int START_PAD          = cwts_pkg::DEF_START_PAD
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        mode_i,
  input  logic                        fault_carriage_i,
  input  logic                        fault_spin_i,
  input  logic [TOT_W-1:0]            total_i,
  input  logic [cwts_pkg::POS_W-1:0]  far_end_i,
  input  logic [cwts_pkg::REG_W-1:0]  spin_per_cstep_i,
  output cwts_pkg::cwts_status_t      status_o,
  output logic [TOT_W-1:0]            step_total_o
);
  import cwts_pkg::*;

  localparam int HOLD_W = $clog2(HOLDOFF_STEPS + 1);

  logic [TOT_W-1:0]   step_q, step_d;
  logic [REG_W-1:0]   sub_q, sub_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               fwd_q, fwd_d;
  logic [HOLD_W-1:0]  hold_q, hold_d;
  logic [FAULT_W-1:0] fault_q, fault_d;
  logic               run_q, run_d;
  logic               spin_q, spin_d;
  logic               carr_q, carr_d;
  logic               at_end;
  logic               pos_gt_far;
  logic               pos_lt_start;
  logic [HOLD_W-1:0]  hold_dec;

  assign at_end       = (step_q >= total_i);
  assign pos_gt_far   = ($signed(pos_q) > $signed(far_end_i));
  assign pos_lt_start = ($signed(pos_q) < $signed(POS_W'(START_PAD)));
  assign hold_dec     = (hold_q != '0) ? hold_q - 1'b1 : hold_q;

  always_comb begin
    step_d  = step_q;
    sub_d   = sub_q;
    pos_d   = pos_q;
    fwd_d   = fwd_q;
    hold_d  = hold_q;
    fault_d = fault_q;
    run_d   = run_q;
    spin_d  = spin_q;
    carr_d  = carr_q;
    if (step_i) begin
      spin_d = 1'b0;
      carr_d = 1'b0;
      if (fault_q == FAULT_NONE) begin
        if (mode_i) begin
          step_d = '0;
          sub_d  = '0;
          pos_d  = '0;
          fwd_d  = 1'b1;
          hold_d = HOLD_W'(HOLDOFF_STEPS);
          run_d  = 1'b1;
        end else if (run_q && !at_end) begin
          if (fault_carriage_i) begin
            fault_d = FAULT_CARRIAGE;
          end else if (fault_spin_i) begin
            fault_d = FAULT_SPIN;
          end else begin
            spin_d = 1'b1;
            hold_d = hold_dec;
            // reverse at either end once the holdoff has run out
            if (hold_dec == '0 && pos_gt_far) begin
              fwd_d  = 1'b0;
              hold_d = HOLD_W'(HOLDOFF_STEPS);
            end else if (hold_dec == '0 && pos_lt_start) begin
              fwd_d  = 1'b1;
              hold_d = HOLD_W'(HOLDOFF_STEPS);
            end
            if (sub_q == spin_per_cstep_i) begin
              carr_d = 1'b1;
              pos_d  = fwd_d ? pos_q + POS_W'(CARRIAGE_STEP_SIZE)
                             : pos_q - POS_W'(CARRIAGE_STEP_SIZE);
              sub_d  = REG_W'(1);
            end else begin
              sub_d = sub_q + 1'b1;
            end
            step_d = step_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      sub_q   <= '0;
      pos_q   <= '0;
      fwd_q   <= 1'b1;
      hold_q  <= HOLD_W'(HOLDOFF_STEPS);
      fault_q <= FAULT_NONE;
      run_q   <= 1'b0;
      spin_q  <= 1'b0;
      carr_q  <= 1'b0;
    end else begin
      step_q  <= step_d;
      sub_q   <= sub_d;
      pos_q   <= pos_d;
      fwd_q   <= fwd_d;
      hold_q  <= hold_d;
      fault_q <= fault_d;
      run_q   <= run_d;
      spin_q  <= spin_d;
      carr_q  <= carr_d;
    end
  end

  assign status_o.run_active = run_q;
  assign status_o.at_end     = at_end;
  assign status_o.fwd        = fwd_q;
  assign status_o.fault      = fault_q;
  assign status_o.spin       = spin_q;
  assign status_o.carr       = carr_q;
  assign step_total_o        = step_q;

endmodule

// ===== hw/rtl/coil_winding_traverse_stepper.sv =====
// Top level of the coil winding traverse stepper: config registers, sequencer, output register.
//
// Usage: each input word is a start (mode 1) or a step tick (mode 0) with the two
// driver fault flags. Each input word yields exactly one output word: the spin and
// carriage pulses for that tick, the carriage direction, percent complete, the
// finished flag and the latched fault code.
// Configuration: write turn_count, coil_length and spin_per_carriage_step through
// cfg_we_i / cfg_index_i / cfg_wdata_i while no word is in flight.
// Timing: a word is taken when in_valid_i is high and in_stall_o low. The block then
// stalls its input while it latches the totals, updates the winding state, loads the
// subtract-and-compare divider, lets it produce the percent bits, flags completion and
// lands the result in the output register; only then can it take the next word.
// Stall: a result waits in the output register while out_stall_i is high; the next
// input word is already accepted, and its result is held back until the slot frees.
// Reset: counters clear, direction is forward, holdoff is full, no run is active,
// turn_count and coil_length read 0 and spin_per_carriage_step reads 1.
`timescale 1ns / 1ps
module coil_winding_traverse_stepper #(
  parameter int STEPS_PER_TURN     = cwts_pkg::DEF_STEPS_PER_TURN,
  parameter int HOLDOFF_STEPS      = cwts_pkg::DEF_HOLDOFF_STEPS,
  parameter int CARRIAGE_STEP_SIZE = cwts_pkg::DEF_CARRIAGE_STEP_SIZE,
  parameter int START_PAD          = cwts_pkg::DEF_START_PAD,
  parameter int END_PAD            = cwts_pkg::DEF_END_PAD
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cwts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cwts_pkg::REG_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            in_mode_i,
  input  logic                            in_fault_carriage_i,
  input  logic                            in_fault_spin_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            out_spin_pulse_o,
  output logic                            out_carriage_pulse_o,
  output logic                            out_carriage_forward_o,
  output logic [cwts_pkg::PCT_W-1:0]      out_percent_done_o,
  output logic                            out_finished_o,
  output logic [cwts_pkg::FAULT_W-1:0]    out_fault_code_o
);
  import cwts_pkg::*;

  localparam int TOT_W = REG_W + $clog2(STEPS_PER_TURN + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_STEP = 3'd2;
  localparam logic [2:0] ST_DIVS = 3'd3;
  localparam logic [2:0] ST_DIVW = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [REG_W-1:0] turn_count_q;
  logic [REG_W-1:0] coil_length_q;
  logic [REG_W-1:0] spin_per_cstep_q;

  logic [2:0]       state_q, state_d;
  logic             mode_q, fc_q, fs_q;
  logic [TOT_W-1:0] total_q;
  logic [POS_W-1:0] far_end_q;

  cwts_status_t     status;
  logic [TOT_W-1:0] step_total;
  logic             div_done;
  logic [PCT_W-1:0] quotient;
  logic             in_take;
  logic             out_load;
  logic             out_take;
  logic [PCT_W-1:0] pct;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_count_q     <= '0;
      coil_length_q    <= '0;
      spin_per_cstep_q <= SPIN_PER_CSTEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TURN_COUNT:     turn_count_q     <= cfg_wdata_i;
        REG_COIL_LENGTH:    coil_length_q    <= cfg_wdata_i;
        REG_SPIN_PER_CSTEP: spin_per_cstep_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_o && !out_stall_i;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_o || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_take) state_d = ST_PREP;
      ST_PREP: state_d = ST_STEP;
      ST_STEP: state_d = ST_DIVS;
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: if (div_done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the input word and the per-run limits
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q <= in_mode_i;
      fc_q   <= in_fault_carriage_i;
      fs_q   <= in_fault_spin_i;
    end
    if (state_q == ST_PREP) begin
      total_q   <= TOT_W'(turn_count_q) * TOT_W'(STEPS_PER_TURN);
      far_end_q <= POS_W'(coil_length_q) * POS_W'(COIL_SCALE) - POS_W'(END_PAD);
    end
  end

  cwts_motion #(
    .TOT_W              (TOT_W),
    .HOLDOFF_STEPS      (HOLDOFF_STEPS),
    .CARRIAGE_STEP_SIZE (CARRIAGE_STEP_SIZE),
    .START_PAD          (START_PAD)
  ) u_motion (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (state_q == ST_STEP),
    .mode_i           (mode_q),
    .fault_carriage_i (fc_q),
    .fault_spin_i     (fs_q),
    .total_i          (total_q),
    .far_end_i        (far_end_q),
    .spin_per_cstep_i (spin_per_cstep_q),
    .status_o         (status),
    .step_total_o     (step_total)
  );

  cwts_div #(
    .TOT_W (TOT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DIVS),
    .dividend_i (step_total),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Zero with no run active; clamp to full once every step is taken, which also covers a zero-turn run
  always_comb begin
    if (!status.run_active) begin
      pct = '0;
    end else if (status.at_end) begin
      pct = PCT_FULL;
    end else begin
      pct = quotient;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_take) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_spin_pulse_o       <= status.spin;
      out_carriage_pulse_o   <= status.carr;
      out_carriage_forward_o <= status.fwd;
      out_percent_done_o     <= pct;
      out_finished_o         <= status.run_active && status.at_end;
      out_fault_code_o       <= status.fault;
    end
  end

endmodule

// ===== hw/rtl/cwts_chk.sv =====
// Port-level checks for the coil winding traverse stepper, bound to the top level.
`timescale 1ns / 1ps
module cwts_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            out_spin_pulse_o,
  input logic                            out_carriage_pulse_o,
  input logic [cwts_pkg::PCT_W-1:0]      out_percent_done_o,
  input logic                            out_finished_o,
  input logic [cwts_pkg::FAULT_W-1:0]    out_fault_code_o
);
  import cwts_pkg::*;

  // A taken word keeps the input stalled while it is worked on
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a word was taken");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A finished run reports full progress
  a_finished_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_finished_o |-> out_percent_done_o == PCT_FULL)
    else $error("finished without full percent");

  // A carriage step only comes with a spin step and never under a latched fault
  a_carr_with_spin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_carriage_pulse_o |->
      out_spin_pulse_o && out_fault_code_o == FAULT_NONE)
    else $error("carriage pulse without spin pulse or under fault");

endmodule

bind coil_winding_traverse_stepper cwts_chk u_cwts_chk (.*);

// ===== tb/tb_coil_winding_traverse_stepper.sv =====
// Testbench for coil_winding_traverse_stepper: predicts every output word and checks it.
`timescale 1ns / 1ps
module tb_coil_winding_traverse_stepper;
  import cwts_pkg::*;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  localparam logic [2:0] SEL_TURNS = 3'(1) << REG_TURN_COUNT;
  localparam logic [2:0] SEL_COIL  = 3'(1) << REG_COIL_LENGTH;
  localparam logic [2:0] SEL_SPC   = 3'(1) << REG_SPIN_PER_CSTEP;
  localparam logic [2:0] SEL_ALL   = SEL_TURNS | SEL_COIL | SEL_SPC;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic               spin;
    logic               carr;
    logic               fwd;
    logic [PCT_W-1:0]   pct;
    logic               fin;
    logic [FAULT_W-1:0] fault;
  } winder_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_TURN_COUNT;
  logic [REG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 in_mode_i = MODE_TICK;
  logic                 in_fault_carriage_i = 1'b0;
  logic                 in_fault_spin_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 out_spin_pulse_o;
  logic                 out_carriage_pulse_o;
  logic                 out_carriage_forward_o;
  logic [PCT_W-1:0]     out_percent_done_o;
  logic                 out_finished_o;
  logic [FAULT_W-1:0]   out_fault_code_o;

  coil_winding_traverse_stepper uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .in_mode_i             (in_mode_i),
    .in_fault_carriage_i   (in_fault_carriage_i),
    .in_fault_spin_i       (in_fault_spin_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_spin_pulse_o      (out_spin_pulse_o),
    .out_carriage_pulse_o  (out_carriage_pulse_o),
    .out_carriage_forward_o(out_carriage_forward_o),
    .out_percent_done_o    (out_percent_done_o),
    .out_finished_o        (out_finished_o),
    .out_fault_code_o      (out_fault_code_o)
  );

  always #1 clk_i = ~clk_i;

  // Register copies and winding state of the predictor
  logic [REG_W-1:0]   cfg_turns = '0;
  logic [REG_W-1:0]   cfg_len = '0;
  logic [REG_W-1:0]   cfg_spc = SPIN_PER_CSTEP_RST;
  logic [23:0]        wind_steps = '0;
  logic [15:0]        wind_sub = '0;
  logic [POS_W-1:0]   wind_pos = '0;
  logic               wind_fwd = 1'b1;
  logic [9:0]         wind_hold = 10'(DEF_HOLDOFF_STEPS);
  logic [FAULT_W-1:0] wind_fault = FAULT_NONE;
  logic               wind_run = 1'b0;

  winder_word_t predicted_words[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  bit           valid_held = 1'b0;

  function automatic int unsigned target_steps();
    return int'(cfg_turns) * DEF_STEPS_PER_TURN;
  endfunction

  function automatic winder_word_t advance_winder(input logic mode, input logic fc,
                                                  input logic fs);
    winder_word_t    w;
    int unsigned     total;
    int              pos_now;
    int              far_end;
    longint unsigned ratio;
    w = '0;
    total = target_steps();
    if (wind_fault == FAULT_NONE) begin
      if (mode == MODE_START) begin
        wind_steps = '0;
        wind_sub   = '0;
        wind_pos   = '0;
        wind_fwd   = 1'b1;
        wind_hold  = 10'(DEF_HOLDOFF_STEPS);
        wind_run   = 1'b1;
      end else if (wind_run && wind_steps < total) begin
        if (fc) begin
          wind_fault = FAULT_CARRIAGE;
        end else if (fs) begin
          wind_fault = FAULT_SPIN;
        end else begin
          w.spin = 1'b1;
          pos_now = int'($signed(wind_pos));
          far_end = int'(cfg_len) * COIL_SCALE - DEF_END_PAD;
          if (wind_hold != 0) wind_hold = wind_hold - 1'b1;
          // both reversal checks see the position from before this step
          if (wind_hold == 0 && pos_now > far_end) begin
            wind_fwd  = 1'b0;
            wind_hold = 10'(DEF_HOLDOFF_STEPS);
          end
          if (wind_hold == 0 && pos_now < DEF_START_PAD) begin
            wind_fwd  = 1'b1;
            wind_hold = 10'(DEF_HOLDOFF_STEPS);
          end
          if (wind_sub == cfg_spc) begin
            w.carr = 1'b1;
            if (wind_fwd) wind_pos = wind_pos + POS_W'(DEF_CARRIAGE_STEP_SIZE);
            else wind_pos = wind_pos - POS_W'(DEF_CARRIAGE_STEP_SIZE);
            wind_sub = '0;
          end
          wind_sub   = wind_sub + 1'b1;
          wind_steps = wind_steps + 1'b1;
        end
      end
    end
    if (wind_run) begin
      if (total == 0) begin
        w.pct = PCT_FULL;
      end else begin
        ratio = 64'(wind_steps) * PCT_SCALE / total;
        w.pct = (ratio > PCT_SCALE) ? PCT_FULL : PCT_W'(ratio);
      end
      w.fin = (wind_steps >= total);
    end
    w.fwd   = wind_fwd;
    w.fault = wind_fault;
    return w;
  endfunction

  // Fault inputs only matter on ticks of an active, unfinished run
  function automatic bit faults_ignored();
    return wind_fault != FAULT_NONE || !wind_run || wind_steps >= target_steps();
  endfunction

  task automatic send_word(input logic mode, input logic fc, input logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
        if (valid_held) in_valid_i <= 1'b0;
        valid_held = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i          <= 1'b1;
    in_mode_i           <= mode;
    in_fault_carriage_i <= fc;
    in_fault_spin_i     <= fs;
    valid_held = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted_words.push_back(advance_winder(mode, fc, fs));
  endtask

  task automatic send_tick();
    logic fc;
    logic fs;
    fc = 1'b0;
    fs = 1'b0;
    if (faults_ignored()) begin
      fc = 1'($urandom_range(0, 1));
      fs = 1'($urandom_range(0, 1));
    end
    send_word(MODE_TICK, fc, fs);
  endtask

  task automatic drain_results();
    if (valid_held) in_valid_i <= 1'b0;
    valid_held = 1'b0;
    burst_left = 0;
    while (predicted_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_TURN_COUNT:     cfg_turns = data;
      REG_COIL_LENGTH:    cfg_len = data;
      REG_SPIN_PER_CSTEP: cfg_spc = data;
      default: ;
    endcase
  endtask

  // Call only with nothing in flight
  task automatic program_regs(input logic [2:0] sel, input logic [REG_W-1:0] turns,
                              input logic [REG_W-1:0] len, input logic [REG_W-1:0] spc);
    if (sel[REG_TURN_COUNT]) write_reg(REG_TURN_COUNT, turns);
    if (sel[REG_COIL_LENGTH]) write_reg(REG_COIL_LENGTH, len);
    if (sel[REG_SPIN_PER_CSTEP]) write_reg(REG_SPIN_PER_CSTEP, spc);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    // no run yet: faults are ignored and nothing moves
    send_word(MODE_TICK, 1'b1, 1'b1);
    send_word(MODE_TICK, 1'b0, 1'b0);
    // zero turns with reset registers: the run is done at once
    send_word(MODE_START, 1'b1, 1'b1);
    send_word(MODE_TICK, 1'b1, 1'b0);
    send_word(MODE_TICK, 1'b0, 1'b1);
    drain_results();
    // largest target, zero spacing: carriage steps on the first tick, then only when the count wraps
    program_regs(SEL_ALL, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_word(MODE_START, 1'b0, 1'b1);
    repeat (4) send_tick();
    drain_results();
    // short coil with negative far end, widest spacing
    program_regs(SEL_COIL | SEL_SPC, '0, 16'h0000, 16'hFFFF);
    send_word(MODE_START, 1'b1, 1'b0);
    repeat (3) send_tick();
    send_word(MODE_START, 1'b0, 1'b0);
    repeat (2) send_tick();
    drain_results();
    program_regs(SEL_TURNS | SEL_SPC, 16'd1, '0, 16'd3);
    send_word(MODE_START, 1'b1, 1'b1);
    repeat (8) send_tick();
  endtask

  task automatic test_long_traverse();
    logic [REG_W-1:0] len;
    int               k;
    len = $urandom_range(0, 1) ? 16'($urandom_range(0, 19)) : 16'($urandom_range(20, 230));
    drain_results();
    program_regs(SEL_ALL, 16'd6, len, 16'd1);
    send_word(MODE_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    for (k = 0; k < 1210; k++) begin
      // change spacing mid-run, takes effect on the next tick
      if (k == 600) begin
        drain_results();
        program_regs(SEL_SPC, '0, '0, 16'($urandom_range(1, 2)));
      end
      send_tick();
    end
    // shrink the target below the steps already taken: percent saturates
    drain_results();
    program_regs(SEL_TURNS, 16'd5, '0, '0);
    repeat (2) send_tick();
  endtask

  task automatic test_random_runs();
    int               sent;
    int               n;
    int               k;
    logic [REG_W-1:0] turns;
    logic [REG_W-1:0] len;
    logic [REG_W-1:0] spc;
    sent = 0;
    while (sent < 150) begin
      case ($urandom_range(0, 5))
        0:       turns = '0;
        1:       turns = 16'hFFFF;
        2:       turns = 16'($urandom);
        default: turns = 16'($urandom_range(1, 3));
      endcase
      len = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
      case ($urandom_range(0, 5))
        0:       spc = '0;
        1:       spc = 16'hFFFF;
        2:       spc = 16'($urandom);
        default: spc = 16'($urandom_range(1, 3));
      endcase
      drain_results();
      program_regs(3'($urandom_range(1, 7)), turns, len, spc);
      send_word(MODE_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      sent++;
      n = $urandom_range(0, 40);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 24) == 0)
          send_word(MODE_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else
          send_tick();
        sent++;
      end
    end
  endtask

  // A latched fault holds until reset, so this runs last
  task automatic test_fault_halt();
    logic fc;
    logic fs;
    drain_results();
    program_regs(SEL_ALL, 16'd2, 16'($urandom_range(0, 300)), 16'd1);
    send_word(MODE_START, 1'b0, 1'b0);
    repeat ($urandom_range(3, 12)) send_tick();
    case ($urandom_range(0, 2))
      0: begin
        fc = 1'b1;
        fs = 1'b0;
      end
      1: begin
        fc = 1'b0;
        fs = 1'b1;
      end
      default: begin
        fc = 1'b1;
        fs = 1'b1;
      end
    endcase
    send_word(MODE_TICK, fc, fs);
    send_word(MODE_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    drain_results();
    program_regs(SEL_ALL, 16'($urandom), 16'($urandom), 16'($urandom));
    repeat (8) send_tick();
    send_word(MODE_START, 1'b0, 1'b0);
  endtask

  // Receiver stall: rotate a pattern, reload it now and then
  logic [31:0] stall_pattern = '0;
  int          stall_age = 0;
  always @(posedge clk_i) begin
    if (stall_age == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pattern = '0;
        1: stall_pattern = $urandom;
        2: stall_pattern = $urandom | $urandom;
        default: stall_pattern = $urandom & $urandom;
      endcase
      stall_age = $urandom_range(16, 96);
    end
    out_stall_i <= stall_pattern[0];
    stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
    stall_age--;
  end

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_words
    winder_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_words.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, expected none, actual spin %0b carr %0b pct %0d",
                 $time, out_spin_pulse_o, out_carriage_pulse_o, out_percent_done_o);
      end else begin
        want = predicted_words.pop_front();
        check_field("spin_pulse", want.spin, out_spin_pulse_o);
        check_field("carriage_pulse", want.carr, out_carriage_pulse_o);
        check_field("carriage_forward", want.fwd, out_carriage_forward_o);
        check_field("percent_done", want.pct, out_percent_done_o);
        check_field("finished", want.fin, out_finished_o);
        check_field("fault_code", want.fault, out_fault_code_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, predicted_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_long_traverse();
    test_random_runs();
    test_fault_halt();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (predicted_words.size() != 0) begin
      mismatch_count++;
      $display("%0t: expected %0d more words, actual 0", $time, predicted_words.size());
    end
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
